>>> src/bsmv_pkg.sv
`default_nettype none
package bsmv_pkg;
  localparam int MAX_PLANES_D = 8;
  localparam int MAX_WORDS_D = 16;
  localparam int MAX_THRESHOLDS_D = 15;
  localparam int MAX_CHANNELS_D = 64;
  localparam int WORD_WIDTH_D = 64;

  localparam logic [1:0] KIND_VEC = 2'd0;
  localparam logic [1:0] KIND_THR = 2'd1;
  localparam logic [1:0] KIND_ROW = 2'd2;
  localparam logic [1:0] KIND_RST = 2'd3;

  localparam logic [2:0] REG_A_BITS = 3'd0;
  localparam logic [2:0] REG_X_BITS = 3'd1;
  localparam logic [2:0] REG_A_SIGNED = 3'd2;
  localparam logic [2:0] REG_X_SIGNED = 3'd3;
  localparam logic [2:0] REG_NUM_WORDS = 3'd4;
  localparam logic [2:0] REG_NUM_THRES = 3'd5;
  localparam logic [2:0] REG_NUM_CHAN = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  plane;
    logic [3:0]  word_index;
    logic [63:0] data;
    logic [3:0]  thres_index;
    logic [5:0]  channel;
    logic signed [31:0] thres_value;
    logic        row_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] row_index;
    logic signed [31:0] accumulator;
    logic [3:0]  crossed;
  } out_item_t;
endpackage
`default_nettype wire

>>> src/bsmv_if.sv
`default_nettype none
interface bsmv_in_if;
  logic valid;
  logic ready;
  bsmv_pkg::in_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface bsmv_out_if;
  logic valid;
  logic ready;
  bsmv_pkg::out_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface
`default_nettype wire

>>> src/bsmv_ram.sv
`default_nettype none
module bsmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/bsmv_front.sv
`default_nettype none
module bsmv_front (
  input  wire logic clk,
  input  wire logic rst,
  bsmv_in_if.sink  in_ch,
  input  wire logic q_full,
  output logic q_push,
  output bsmv_pkg::in_item_t q_item
);
  import bsmv_pkg::*;
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;
  always_comb begin
    q_item = in_ch.item;
    if (!(in_ch.item.kind inside {KIND_VEC, KIND_ROW})) q_item.data = '0;
    if (in_ch.item.kind != KIND_THR) q_item.thres_value = '0;
  end
  logic unused;
  assign unused = clk ^ rst;
endmodule
`default_nettype wire

>>> src/bsmv_queue.sv
`default_nettype none
module bsmv_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire bsmv_pkg::in_item_t wdata,
  output logic full,
  input  wire logic pop,
  output logic empty,
  output bsmv_pkg::in_item_t rdata
);
  import bsmv_pkg::*;
  localparam int AW = $clog2(DEPTH);
  in_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  assign full = cnt == (AW+1)'(DEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> src/bsmv_back.sv
`default_nettype none
module bsmv_back #(
  parameter int MAX_PLANES = 8,
  parameter int MAX_WORDS = 16,
  parameter int MAX_THRESHOLDS = 15,
  parameter int MAX_CHANNELS = 64,
  parameter int WORD_WIDTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic q_empty,
  input  wire bsmv_pkg::in_item_t q_item,
  output logic q_pop,
  bsmv_out_if.source out_ch
);
  import bsmv_pkg::*;
  localparam int VD = MAX_PLANES * MAX_WORDS;
  localparam int TD = MAX_THRESHOLDS * MAX_CHANNELS;
  localparam int VA = $clog2(VD);
  localparam int TA = $clog2(TD);
  localparam int PW = $clog2(MAX_PLANES+1);
  localparam int WW = $clog2(MAX_WORDS+1);
  localparam int NTW = $clog2(MAX_THRESHOLDS+1);
  localparam int NCW = $clog2(MAX_CHANNELS+1);
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PCW = $clog2(WORD_WIDTH+1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MAC = 5'b00010, S_TH = 5'b00100,
    S_OUT = 5'b01000, S_WAIT = 5'b10000
  } state_t;
  state_t state;

  logic [3:0] a_bits, x_bits, num_thresholds;
  logic a_signed, x_signed;
  logic [4:0] num_words;
  logic [6:0] num_channels;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_bits <= 4'd1; x_bits <= 4'd1; a_signed <= 1'b0; x_signed <= 1'b0;
      num_words <= 5'd1; num_thresholds <= 4'd0; num_channels <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_BITS: a_bits <= cfg_data[3:0];
        REG_X_BITS: x_bits <= cfg_data[3:0];
        REG_A_SIGNED: a_signed <= cfg_data[0];
        REG_X_SIGNED: x_signed <= cfg_data[0];
        REG_NUM_WORDS: num_words <= cfg_data[4:0];
        REG_NUM_THRES: num_thresholds <= cfg_data[3:0];
        REG_NUM_CHAN: num_channels <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] ab, xb, nw, nt, nc;
  always_comb begin
    ab = (a_bits == 0) ? 32'd1 : (32'(a_bits) > MAX_PLANES ? MAX_PLANES : 32'(a_bits));
    xb = (x_bits == 0) ? 32'd1 : (32'(x_bits) > MAX_PLANES ? MAX_PLANES : 32'(x_bits));
    nw = (num_words == 0) ? 32'd1 : (32'(num_words) > MAX_WORDS ? MAX_WORDS : 32'(num_words));
    nt = 32'(num_thresholds) > MAX_THRESHOLDS ? MAX_THRESHOLDS : 32'(num_thresholds);
    nc = (num_channels == 0) ? 32'd1
       : (32'(num_channels) > MAX_CHANNELS ? MAX_CHANNELS : 32'(num_channels));
  end

  in_item_t cur;
  logic [PW-1:0] p;
  logic [NTW-1:0] t;
  logic rd_ok;
  logic [31:0] row_sum;
  logic [15:0] row_counter;
  logic [CW-1:0] channel_counter, ch;
  logic [NTW-1:0] cnt;
  logic neg_a;

  logic v_we, t_we;
  logic [VA-1:0] v_raddr, v_waddr;
  logic [TA-1:0] t_raddr, t_waddr;
  logic [WORD_WIDTH-1:0] v_rdata;
  logic [31:0] t_rdata;

  assign v_we = (state == S_IDLE) && !q_empty && q_item.kind == KIND_VEC
    && 32'(q_item.plane) < MAX_PLANES && 32'(q_item.word_index) < MAX_WORDS;
  assign t_we = (state == S_IDLE) && !q_empty && q_item.kind == KIND_THR
    && 32'(q_item.thres_index) < MAX_THRESHOLDS && 32'(q_item.channel) < MAX_CHANNELS;
  assign v_waddr = VA'(32'(q_item.plane) * MAX_WORDS + 32'(q_item.word_index));
  assign t_waddr = TA'(32'(q_item.thres_index) * MAX_CHANNELS + 32'(q_item.channel));
  assign v_raddr = VA'(32'(p) * MAX_WORDS + 32'(cur.word_index));
  assign t_raddr = TA'(32'(t) * MAX_CHANNELS + 32'(ch));

  bsmv_ram #(.WIDTH(WORD_WIDTH), .DEPTH(VD)) u_vec (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(q_item.data[WORD_WIDTH-1:0]),
    .raddr(v_raddr), .rdata(v_rdata));
  bsmv_ram #(.WIDTH(32), .DEPTH(TD)) u_thr (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(q_item.thres_value),
    .raddr(t_raddr), .rdata(t_rdata));

  logic [PW-1:0] p_rd;
  logic [PCW-1:0] pc;
  logic [31:0] term;
  logic neg_x;
  always_comb begin
    pc = '0;
    for (int i = 0; i < WORD_WIDTH; i++)
      pc = pc + PCW'(cur.data[i] & v_rdata[i]);
    term = 32'(pc) << (32'(cur.plane) + 32'(p_rd));
    neg_x = x_signed && 32'(p_rd) == xb - 1;
  end

  logic [NTW-1:0] t_rd;
  logic t_rd_ok;

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign out_ch.valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    if (rst) begin
      state <= S_IDLE;
      row_sum <= '0; row_counter <= '0; channel_counter <= '0;
      p <= '0; t <= '0; rd_ok <= 1'b0; t_rd_ok <= 1'b0; cnt <= '0;
      p_rd <= '0; t_rd <= '0; ch <= '0; neg_a <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          p <= '0; rd_ok <= 1'b0;
          if (!q_empty) begin
            if (q_item.kind == KIND_RST) begin
              row_counter <= '0; channel_counter <= '0; row_sum <= '0;
            end else if (q_item.kind == KIND_ROW) begin
              neg_a <= a_signed && 32'(q_item.plane) == ab - 1;
              if (32'(q_item.plane) < ab && 32'(q_item.word_index) < nw) state <= S_MAC;
              else state <= S_WAIT;
            end
          end
        end
        S_MAC: begin
          if (rd_ok) row_sum <= row_sum + ((neg_a != neg_x) ? (32'd0 - term) : term);
          p_rd <= p;
          if (32'(p) < xb) begin
            p <= p + 1'b1; rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0; state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!cur.row_end) state <= S_IDLE;
          else begin
            ch <= (32'(channel_counter) < nc) ? channel_counter : '0;
            t <= '0; t_rd_ok <= 1'b0; cnt <= '0; state <= S_TH;
          end
        end
        S_TH: begin
          if (t_rd_ok && $signed(row_sum) >= $signed(t_rdata)) cnt <= cnt + 1'b1;
          t_rd <= t;
          if (32'(t) < nt) begin
            t <= t + 1'b1; t_rd_ok <= 1'b1;
          end else begin
            t_rd_ok <= 1'b0; state <= S_OUT;
            out_ch.item.row_index <= row_counter;
            out_ch.item.accumulator <= row_sum;
            out_ch.item.crossed <= 4'(cnt + NTW'(t_rd_ok && $signed(row_sum) >= $signed(t_rdata)));
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE;
            row_counter <= row_counter + 1'b1;
            channel_counter <= (32'(ch) + 1 >= nc) ? '0 : ch + 1'b1;
            row_sum <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  logic unused;
  assign unused = ^{t_rd, NCW'(0), WW'(0), cur.thres_value, cur.thres_index, cur.channel};
endmodule
`default_nettype wire

>>> src/bit_serial_matvec_threshold.sv
`default_nettype none
// bit-serial matrix-vector multiply with threshold count
// in: valid/ready item channel; kind selects vector load, threshold load,
//   matrix row word or row count restart
// out: valid/ready channel with row_index, accumulator, crossed, one item
//   per matrix word marked row_end
// cfg: write enable, index and data; write only while idle
// a front stage moves items into a four-deep queue; the back end drains it
// an accepted item is registered in the queue before the back end sees it
// load and restart items are handled in the idle state of the back end
// a matrix word inside the shape passes through MAC and WAIT, one vector store read
//   per plane; a word outside the shape goes straight from idle to WAIT
// a row end adds the threshold pass and OUT, one threshold read per cycle
// the result register holds while out.ready is low; the queue keeps taking
//   items until it fills
// reset clears counters and row sum and sets config to defaults; stores are
//   undefined until written, no clearing pass
module bit_serial_matvec_threshold
  import bsmv_pkg::*;
#(
  parameter int MAX_PLANES = MAX_PLANES_D,
  parameter int MAX_WORDS = MAX_WORDS_D,
  parameter int MAX_THRESHOLDS = MAX_THRESHOLDS_D,
  parameter int MAX_CHANNELS = MAX_CHANNELS_D,
  parameter int WORD_WIDTH = WORD_WIDTH_D
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  bsmv_in_if.sink  in_ch,
  bsmv_out_if.source out_ch
);
  logic q_full, q_push, q_empty, q_pop;
  in_item_t q_wdata, q_rdata;

  bsmv_front u_front (.clk, .rst, .in_ch, .q_full, .q_push, .q_item(q_wdata));
  bsmv_queue #(.DEPTH(4)) u_queue (.clk, .rst, .push(q_push), .wdata(q_wdata),
    .full(q_full), .pop(q_pop), .empty(q_empty), .rdata(q_rdata));
  bsmv_back #(.MAX_PLANES(MAX_PLANES), .MAX_WORDS(MAX_WORDS),
    .MAX_THRESHOLDS(MAX_THRESHOLDS), .MAX_CHANNELS(MAX_CHANNELS),
    .WORD_WIDTH(WORD_WIDTH)) u_back (.clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .q_empty, .q_item(q_rdata), .q_pop, .out_ch);

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push) else $error("push into full queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.item))
    else $error("result dropped");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

>>> test/tb_bit_serial_matvec_threshold.sv
`timescale 1ns / 1ps
module tb_bit_serial_matvec_threshold;
  import bsmv_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int TEST_CHANNELS = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [6:0] cfg_data;

  bsmv_in_if in_if ();
  bsmv_out_if out_if ();

  bit_serial_matvec_threshold u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [63:0] vec_mem [MAX_PLANES_D * MAX_WORDS_D];
  logic [31:0] thr_mem [MAX_THRESHOLDS_D * MAX_CHANNELS_D];
  logic [31:0] row_acc;
  logic [15:0] row_cnt;
  logic [5:0] chan_cnt;
  logic [3:0] r_a_bits, r_x_bits, r_num_thres;
  logic r_a_signed, r_x_signed;
  logic [4:0] r_num_words;
  logic [6:0] r_num_chan;

  out_item_t pending_rows[$];
  int errors = 0;
  int rows_checked = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  function automatic int clamp_to(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void model_item(in_item_t it);
    int ab, xb, nw, nt, nc, ch, cnt;
    logic [31:0] term;
    logic neg_a, neg_x;
    out_item_t res;
    ab = clamp_to(int'(r_a_bits), MAX_PLANES_D);
    xb = clamp_to(int'(r_x_bits), MAX_PLANES_D);
    nw = clamp_to(int'(r_num_words), MAX_WORDS_D);
    nt = (int'(r_num_thres) > MAX_THRESHOLDS_D) ? MAX_THRESHOLDS_D : int'(r_num_thres);
    nc = clamp_to(int'(r_num_chan), MAX_CHANNELS_D);
    case (it.kind)
      KIND_VEC: begin
        vec_mem[it.plane * MAX_WORDS_D + it.word_index] = it.data;
      end
      KIND_THR: begin
        if (it.thres_index < MAX_THRESHOLDS_D)
          thr_mem[it.thres_index * MAX_CHANNELS_D + it.channel] = it.thres_value;
      end
      KIND_RST: begin
        row_acc = '0;
        row_cnt = '0;
        chan_cnt = '0;
      end
      default: begin
        if (it.plane < ab && it.word_index < nw) begin
          neg_a = r_a_signed && (it.plane == ab - 1);
          for (int p = 0; p < xb; p++) begin
            term = 32'($countones(it.data & vec_mem[p * MAX_WORDS_D + it.word_index]));
            term = term << (it.plane + p);
            neg_x = r_x_signed && (p == xb - 1);
            row_acc = (neg_a != neg_x) ? row_acc - term : row_acc + term;
          end
        end
        if (it.row_end) begin
          ch = (chan_cnt < nc) ? int'(chan_cnt) : 0;
          cnt = 0;
          for (int t = 0; t < nt; t++)
            if ($signed(row_acc) >= $signed(thr_mem[t * MAX_CHANNELS_D + ch])) cnt++;
          res.row_index = row_cnt;
          res.accumulator = row_acc;
          res.crossed = 4'(cnt);
          pending_rows = {pending_rows, res};
          row_cnt = row_cnt + 1'b1;
          chan_cnt = (ch + 1 >= nc) ? 6'd0 : 6'(ch + 1);
          row_acc = '0;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.item;
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row %0d", got.row_index));
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (got.row_index !== want.row_index)
          report_mismatch($sformatf("row_index %0d want %0d", got.row_index, want.row_index));
        if (got.accumulator !== want.accumulator)
          report_mismatch($sformatf("row %0d accumulator %0d want %0d", want.row_index,
                                    got.accumulator, want.accumulator));
        if (got.crossed !== want.crossed)
          report_mismatch($sformatf("row %0d crossed %0d want %0d", want.row_index,
                                    got.crossed, want.crossed));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(in_item_t it);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.item <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    model_item(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_A_BITS: r_a_bits = val[3:0];
      REG_X_BITS: r_x_bits = val[3:0];
      REG_A_SIGNED: r_a_signed = val[0];
      REG_X_SIGNED: r_x_signed = val[0];
      REG_NUM_WORDS: r_num_words = val[4:0];
      REG_NUM_THRES: r_num_thres = val[3:0];
      REG_NUM_CHAN: r_num_chan = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t blank_item(logic [1:0] k);
    in_item_t it;
    it = '0;
    it.kind = k;
    return it;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t row_word(int pl, int wi, bit last);
    in_item_t it;
    it = blank_item(KIND_ROW);
    it.plane = 3'(pl);
    it.word_index = 4'(wi);
    it.data = rand_word();
    it.row_end = last;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.kind = 2'($urandom_range(0, 3));
    it.plane = 3'($urandom);
    it.word_index = 4'($urandom);
    it.data = rand_word();
    it.thres_index = 4'($urandom);
    it.channel = 6'($urandom);
    it.thres_value = $urandom;
    it.row_end = 1'($urandom);
    return it;
  endfunction

  task automatic test_store_loads();
    in_item_t it;
    for (int p = 0; p < MAX_PLANES_D; p++)
      for (int w = 0; w < MAX_WORDS_D; w++) begin
        it = blank_item(KIND_VEC);
        it.plane = 3'(p);
        it.word_index = 4'(w);
        it.data = rand_word();
        send_item(it);
      end
    for (int c = 0; c < TEST_CHANNELS; c++)
      for (int t = 0; t < MAX_THRESHOLDS_D; t++) begin
        it = blank_item(KIND_THR);
        it.thres_index = 4'(t);
        it.channel = 6'(c);
        case ($urandom_range(0, 5))
          0: it.thres_value = 32'sh8000_0000;
          1: it.thres_value = 32'sh7fff_ffff;
          2: it.thres_value = $urandom_range(0, 200) - 100;
          default: it.thres_value = $signed($urandom) >>> $urandom_range(0, 24);
        endcase
        send_item(it);
      end
    wait_drained();
  endtask

  task automatic test_directed();
    in_item_t it;
    write_reg(REG_NUM_THRES, 7'd15);
    write_reg(REG_NUM_CHAN, 7'd8);
    it = row_word(0, 0, 1);
    it.data = '1;
    send_item(it);
    it.data = '0;
    send_item(it);
    it = row_word(0, 0, 0);
    send_item(it);
    it = row_word(5, 0, 0);
    send_item(it);
    it = row_word(0, 9, 1);
    send_item(it);
    it = row_word(0, 0, 0);
    send_item(it);
    send_item(blank_item(KIND_RST));
    it = row_word(0, 0, 1);
    send_item(it);
    it = blank_item(KIND_THR);
    it.thres_index = 4'd15;
    it.channel = 6'd63;
    it.thres_value = 32'sh7fff_ffff;
    send_item(it);
    it = row_word(7, 15, 1);
    it.data = '1;
    send_item(it);
    wait_drained();
  endtask

  task automatic test_setting(int ab_w, int xb_w, int as_w, int xs_w, int nw_w,
                              int nt_w, int nc_w, int rows);
    int ab, nw;
    in_item_t it;
    write_reg(REG_A_BITS, 7'(ab_w));
    write_reg(REG_X_BITS, 7'(xb_w));
    write_reg(REG_A_SIGNED, 7'(as_w));
    write_reg(REG_X_SIGNED, 7'(xs_w));
    write_reg(REG_NUM_WORDS, 7'(nw_w));
    write_reg(REG_NUM_THRES, 7'(nt_w));
    write_reg(REG_NUM_CHAN, 7'(nc_w));
    ab = clamp_to(ab_w, MAX_PLANES_D);
    nw = clamp_to(nw_w, MAX_WORDS_D);
    for (int r = 0; r < rows; r++) begin
      case ($urandom_range(0, 9))
        0: begin
          it = noise_item();
          // keep noise threshold writes on loaded channels when thresholds are counted
          if (it.kind == KIND_THR && nt_w != 0)
            it.channel = 6'(it.channel % TEST_CHANNELS);
          send_item(it);
        end
        1: begin
          // broken row: random words, some outside the shape
          repeat ($urandom_range(1, 4))
            send_item(row_word($urandom_range(0, 7), $urandom_range(0, 15), 0));
          send_item(row_word($urandom_range(0, 7), $urandom_range(0, 15), 1));
        end
        default: begin
          for (int p = 0; p < ab; p++)
            for (int w = 0; w < nw; w++)
              send_item(row_word(p, w, p == ab - 1 && w == nw - 1));
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.item <= '0;
    row_acc = '0;
    row_cnt = '0;
    chan_cnt = '0;
    r_a_bits = 4'd1;
    r_x_bits = 4'd1;
    r_a_signed = 1'b0;
    r_x_signed = 1'b0;
    r_num_words = 5'd1;
    r_num_thres = 4'd0;
    r_num_chan = 7'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_store_loads();
    test_directed();
    test_setting(1, 1, 0, 0, 1, 15, 8, 40);
    test_setting(8, 8, 1, 1, 16, 15, 8, 3);
    test_setting(0, 0, 1, 0, 0, 3, 0, 30);
    test_setting(15, 12, 0, 1, 31, 0, 127, 1);
    test_setting(3, 2, 1, 1, 2, 7, 5, 30);
    test_setting(2, 4, 0, 1, 3, 15, 3, 30);
    idle_on = 1'b0;
    test_setting(4, 3, 1, 0, 1, 0, 64, 30);

    $display("sent %0d items, checked %0d rows over seven register settings", items_sent,
             rows_checked);
    $display("settings spanned 1 to 8 planes, 1 to 16 words, signed and unsigned operands");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
